// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/iap_pkg.sv -----
// ----------------------------------------------------------------------------
// iap_pkg
// constants and types of the inertial sensor angle packet parser
// ----------------------------------------------------------------------------
package iap_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'h53;
    // header bytes seed the packet sum
    localparam logic [7:0] HDR_SUM    = HDR_FIRST + HDR_SECOND;

    localparam int unsigned DATA_BYTES = 9;
    localparam int unsigned STORE_DEPTH = DATA_BYTES - 1;
    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] SUM_POS = POS_W'(DATA_BYTES - 1);

    // raw words above half a turn wrap negative
    localparam logic [15:0] HALF_TURN_RAW = 16'd32768;

    localparam int unsigned ANGLE_W = 17;
    localparam int unsigned WORD_W  = 16;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_DATA  = 2'd2
    } t_phase;

    typedef logic signed [ANGLE_W-1:0] t_angle;

    function automatic t_angle wrap_angle(input logic [WORD_W-1:0] raw);
        t_angle v;
        v = t_angle'({(raw > HALF_TURN_RAW), raw});
        return v;
    endfunction

endpackage

// ----- sv/iap_if.sv -----
// ----------------------------------------------------------------------------
// iap_rx_if / iap_angle_if / iap_cfg_if
// valid-ready channels of the angle packet parser
// ----------------------------------------------------------------------------
interface iap_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iap_angle_if;
    logic                           valid;
    logic                           ready;
    iap_pkg::t_angle                roll_angle;
    iap_pkg::t_angle                pitch_angle;
    iap_pkg::t_angle                yaw_angle;
    logic [iap_pkg::WORD_W-1:0]     extra_word;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, output extra_word, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, input extra_word, output ready);
endinterface

interface iap_cfg_if;
    logic valid;
    logic ready;
    logic yaw_unsigned_mode;

    modport source (output valid, output yaw_unsigned_mode, input ready);
    modport sink   (input valid, input yaw_unsigned_mode, output ready);
endinterface

// ----- sv/imu_angle_packet_parser.sv -----
// ----------------------------------------------------------------------------
// imu_angle_packet_parser
// byte-wise parser for sensor angle packets with an 8-bit sum check
// ----------------------------------------------------------------------------
//  channel   dir  word                                             handshake
//  i_rx      in   rx_byte[7:0]                                     valid/ready
//  o_angle   out  roll, pitch, yaw (17b signed), extra_word (16b)  valid/ready
//  i_cfg     in   yaw_unsigned_mode                                valid/ready
//
//  one byte is taken per cycle while i_rx.ready is high; a result shows in the cycle after its sum byte
//  the result register stalls input only while it is full and not taken
//  i_cfg.ready is always high
//  synchronous active-low reset returns to header hunt, clears mode and valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_angle_packet_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iap_rx_if.sink            i_rx,
    iap_cfg_if.sink           i_cfg,
    iap_angle_if.source       o_angle
);

    iap_pkg::t_phase                    r_phase, n_phase;
    logic [iap_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [7:0]                         r_sum, n_sum;
    logic [7:0]                         r_store [iap_pkg::STORE_DEPTH];
    logic                               r_yaw_mode;

    logic                               r_out_valid;
    iap_pkg::t_angle                    r_roll, r_pitch, r_yaw;
    logic [iap_pkg::WORD_W-1:0]         r_extra;

    logic                               accept;
    logic                               store_we;
    logic                               emit;
    logic [iap_pkg::WORD_W-1:0]         raw_roll, raw_pitch, raw_yaw, raw_extra;

    assign i_rx.ready  = !r_out_valid || o_angle.ready;
    assign accept      = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    // packet words, low byte first
    assign raw_roll  = {r_store[1], r_store[0]};
    assign raw_pitch = {r_store[3], r_store[2]};
    assign raw_yaw   = {r_store[5], r_store[4]};
    assign raw_extra = {r_store[7], r_store[6]};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_sum    = r_sum;
        store_we = 1'b0;
        emit     = 1'b0;
        if (accept) begin
            case (r_phase)
                iap_pkg::PH_HUNT2: begin
                    if (i_rx.rx_byte == iap_pkg::HDR_SECOND) begin
                        n_phase = iap_pkg::PH_DATA;
                        n_pos   = '0;
                        n_sum   = iap_pkg::HDR_SUM;
                    end else begin
                        n_phase = iap_pkg::PH_HUNT1;
                    end
                end
                iap_pkg::PH_DATA: begin
                    if (r_pos < iap_pkg::SUM_POS) begin
                        store_we = 1'b1;
                        n_sum    = r_sum + i_rx.rx_byte;
                        n_pos    = r_pos + 1'b1;
                    end else begin
                        n_phase = iap_pkg::PH_HUNT1;
                        n_pos   = '0;
                        emit    = (r_sum == i_rx.rx_byte);
                    end
                end
                default: begin
                    n_phase = (i_rx.rx_byte == iap_pkg::HDR_FIRST) ?
                              iap_pkg::PH_HUNT2 : iap_pkg::PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= iap_pkg::PH_HUNT1;
            r_pos   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_pos[2:0]] <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_yaw_mode <= i_cfg.yaw_unsigned_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_angle.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_roll  <= iap_pkg::wrap_angle(raw_roll);
            r_pitch <= iap_pkg::wrap_angle(raw_pitch);
            r_yaw   <= r_yaw_mode ? iap_pkg::t_angle'({1'b0, raw_yaw})
                                  : iap_pkg::wrap_angle(raw_yaw);
            r_extra <= raw_extra;
        end
    end

    assign o_angle.valid       = r_out_valid;
    assign o_angle.roll_angle  = r_roll;
    assign o_angle.pitch_angle = r_pitch;
    assign o_angle.yaw_angle   = r_yaw;
    assign o_angle.extra_word  = r_extra;

    `ASSERT_CLK(a_rise_after_sum, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(accept && r_phase == iap_pkg::PH_DATA && r_pos == iap_pkg::SUM_POS), "result without a sum byte")
    `ASSERT_CLK(a_pos_in_range, i_clk, i_rst_n, r_pos <= iap_pkg::SUM_POS, "byte position past sum byte")
    `ASSERT_CLK(a_pos_idle_zero, i_clk, i_rst_n, (r_phase != iap_pkg::PH_DATA) |-> (r_pos == '0), "byte position nonzero while hunting")
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, (r_out_valid && !o_angle.ready) |=> (r_out_valid && $stable(r_roll) && $stable(r_extra)), "stalled result lost")
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule
